FILE: rtl/srdg_pkg.sv
// shared constants and types of the stepper ramp delay generator
package srdg_pkg;

  localparam int unsigned CountBits = 32;
  localparam int unsigned DataBits  = 32;
  localparam int unsigned DelayBits = 24;
  localparam int unsigned DivBits   = 32;
  localparam int unsigned DivCntW   = $clog2(DivBits);

  localparam logic [DelayBits-1:0] DelayMax = {DelayBits{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_APPLY,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    OP_DECEL_GOAL,
    OP_SLOW_CRUISE,
    OP_FAST_CRUISE
  } ramp_op_e;

endpackage

FILE: rtl/stepper_ramp_delay_generator.sv
// top level: step request sequencer, ramp state and result register
// Each accepted step request yields one result item. A request that halts, loads the first
// delay, holds the delay or keeps slewing goes from evaluation to the output state; a
// request that accelerates or decelerates passes through the bit-serial divider that forms
// round(2d / (4n +/- 1)) one quotient bit per cycle over 32 bits, then an apply state.
// One request is in work at a time; the next request is accepted as soon as the result
// has been moved into the output register, even if that result has not yet been taken.
module stepper_ramp_delay_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [srdg_pkg::DelayBits-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [srdg_pkg::DataBits-1:0]    goal_step_i,
  input  logic [srdg_pkg::DelayBits-1:0]   cruise_delay_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [srdg_pkg::DelayBits-1:0]   step_delay_o,
  output logic                             halted_o,
  output logic                             is_slewing_o,
  output logic [srdg_pkg::DataBits-1:0]    steps_done_o
);

  srdg_pkg::state_e   state_q, state_d;
  srdg_pkg::ramp_op_e op_q, op_d;

  logic [srdg_pkg::DelayBits-1:0] first_q;
  logic [srdg_pkg::DataBits-1:0]  goal_q;
  logic [srdg_pkg::DelayBits-1:0] cruise_q;
  logic [srdg_pkg::CountBits-1:0] step_count_q, step_count_d;
  logic [srdg_pkg::DataBits-1:0]  ramp_index_q, ramp_index_d;
  logic [srdg_pkg::DataBits-1:0]  ramp_delay_q, ramp_delay_d;
  logic [srdg_pkg::DelayBits-1:0] latch_q, latch_d;
  logic                           halt_q, halt_d;
  logic                           load_q, load_d;

  logic                           out_valid_q, out_valid_d;
  logic [srdg_pkg::DelayBits-1:0] step_delay_q, step_delay_d;
  logic                           halted_q, halted_d;
  logic                           slewing_q, slewing_d;
  logic [srdg_pkg::DataBits-1:0]  steps_done_q, steps_done_d;

  logic                           div_start;
  logic [srdg_pkg::DivBits-1:0]   div_num;
  logic [srdg_pkg::DivBits-1:0]   div_den;
  logic                           div_done;
  logic [srdg_pkg::DivBits-1:0]   div_quo;

  logic [srdg_pkg::DataBits-1:0]  st32;
  logic [srdg_pkg::DataBits-1:0]  est;
  logic [srdg_pkg::DataBits-1:0]  cruise32;
  logic [srdg_pkg::DataBits-1:0]  index_dec;
  logic [srdg_pkg::DataBits-1:0]  den_fast;
  logic [srdg_pkg::DataBits-1:0]  den_slow;
  logic [srdg_pkg::DelayBits-1:0] latch_eff;
  logic [srdg_pkg::DataBits-1:0]  delay_new;
  logic                           out_load;

  assign st32      = srdg_pkg::DataBits'(step_count_q);
  assign est       = st32 + ramp_index_q;
  assign cruise32  = srdg_pkg::DataBits'(cruise_q);
  assign index_dec = ramp_index_q - 1'b1;
  assign den_fast  = {ramp_index_q[srdg_pkg::DataBits-3:0], 2'b01};
  assign den_slow  = {index_dec[srdg_pkg::DataBits-3:0], 2'b00} - 1'b1;
  assign latch_eff = (latch_q != '0 && latch_q != cruise_q) ? '0 : latch_q;
  assign delay_new = (op_q == srdg_pkg::OP_FAST_CRUISE) ? ramp_delay_q - div_quo
                                                        : ramp_delay_q + div_quo;
  assign out_load  = !out_valid_q || out_ready_i;

  srdg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    step_count_d = step_count_q;
    ramp_index_d = ramp_index_q;
    ramp_delay_d = ramp_delay_q;
    latch_d      = latch_q;
    halt_d       = halt_q;
    load_d       = load_q;
    out_valid_d  = out_valid_q;
    step_delay_d = step_delay_q;
    halted_d     = halted_q;
    slewing_d    = slewing_q;
    steps_done_d = steps_done_q;
    div_start    = 1'b0;
    div_den      = den_fast;
    in_ready_o   = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      srdg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = srdg_pkg::ST_EVAL;
        end
      end
      srdg_pkg::ST_EVAL: begin
        state_d = srdg_pkg::ST_OUT;
        load_d  = 1'b0;
        if (st32 >= goal_q && ramp_index_q <= srdg_pkg::DataBits'(1)) begin
          ramp_index_d = '0;
          halt_d       = 1'b1;
        end else begin
          halt_d       = 1'b0;
          latch_d      = latch_eff;
          step_count_d = step_count_q + 1'b1;
          if (ramp_index_q == '0) begin
            ramp_delay_d = srdg_pkg::DataBits'(first_q);
            ramp_index_d = srdg_pkg::DataBits'(1);
            load_d       = 1'b1;
          end else if (est == goal_q) begin
            state_d = srdg_pkg::ST_OUT;
          end else if (est > goal_q) begin
            op_d         = srdg_pkg::OP_DECEL_GOAL;
            ramp_index_d = index_dec;
            div_den      = den_slow;
            div_start    = 1'b1;
            state_d      = srdg_pkg::ST_DIV;
          end else if (latch_eff == '0 && ramp_delay_q < cruise32) begin
            op_d         = srdg_pkg::OP_SLOW_CRUISE;
            ramp_index_d = index_dec;
            div_den      = den_slow;
            div_start    = 1'b1;
            state_d      = srdg_pkg::ST_DIV;
          end else if (latch_eff == '0 && ramp_delay_q > cruise32) begin
            op_d         = srdg_pkg::OP_FAST_CRUISE;
            ramp_index_d = ramp_index_q + 1'b1;
            div_den      = den_fast;
            div_start    = 1'b1;
            state_d      = srdg_pkg::ST_DIV;
          end
        end
      end
      srdg_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = srdg_pkg::ST_APPLY;
        end
      end
      srdg_pkg::ST_APPLY: begin
        ramp_delay_d = delay_new;
        state_d      = srdg_pkg::ST_OUT;
        case (op_q)
          srdg_pkg::OP_DECEL_GOAL: begin
            latch_d = '0;
          end
          srdg_pkg::OP_SLOW_CRUISE: begin
            if (delay_new >= cruise32) begin
              latch_d = cruise_q;
            end
          end
          srdg_pkg::OP_FAST_CRUISE: begin
            if (delay_new <= cruise32) begin
              latch_d = cruise_q;
            end
          end
          default: begin
            latch_d = latch_q;
          end
        endcase
      end
      srdg_pkg::ST_OUT: begin
        if (out_load) begin
          out_valid_d  = 1'b1;
          halted_d     = halt_q;
          steps_done_d = srdg_pkg::DataBits'(step_count_q);
          if (halt_q) begin
            step_delay_d = '0;
            slewing_d    = 1'b0;
          end else if (load_q) begin
            step_delay_d = ramp_delay_q[srdg_pkg::DelayBits-1:0];
            slewing_d    = 1'b0;
          end else if (latch_q != '0) begin
            step_delay_d = latch_q;
            slewing_d    = 1'b1;
          end else begin
            slewing_d = 1'b0;
            if (ramp_delay_q > srdg_pkg::DataBits'(srdg_pkg::DelayMax)) begin
              step_delay_d = srdg_pkg::DelayMax;
            end else begin
              step_delay_d = ramp_delay_q[srdg_pkg::DelayBits-1:0];
            end
          end
          state_d = srdg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = srdg_pkg::ST_IDLE;
      end
    endcase
  end

  // numerator 2d + den/2, wrapping at the data width
  assign div_num = {ramp_delay_q[srdg_pkg::DataBits-2:0], 1'b0}
                 + {1'b0, div_den[srdg_pkg::DataBits-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= srdg_pkg::ST_IDLE;
      op_q         <= srdg_pkg::OP_DECEL_GOAL;
      first_q      <= '0;
      step_count_q <= '0;
      ramp_index_q <= '0;
      ramp_delay_q <= '0;
      latch_q      <= '0;
      halt_q       <= 1'b0;
      load_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      step_count_q <= step_count_d;
      ramp_index_q <= ramp_index_d;
      ramp_delay_q <= ramp_delay_d;
      latch_q      <= latch_d;
      halt_q       <= halt_d;
      load_q       <= load_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        first_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      goal_q   <= goal_step_i;
      cruise_q <= cruise_delay_i;
    end
    step_delay_q <= step_delay_d;
    halted_q     <= halted_d;
    slewing_q    <= slewing_d;
    steps_done_q <= steps_done_d;
  end

  assign out_valid_o  = out_valid_q;
  assign step_delay_o = step_delay_q;
  assign halted_o     = halted_q;
  assign is_slewing_o = slewing_q;
  assign steps_done_o = steps_done_q;

`ifndef ASSERT_OFF
  a_halt_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && halted_o |-> step_delay_o == '0 && !is_slewing_o)
    else $error("halted item carries a delay or slewing flag");

  a_slew_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_slewing_o |-> step_delay_o != '0)
    else $error("slewing item with zero delay");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == srdg_pkg::ST_DIV)
    else $error("divider finished outside the divide phase");

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == srdg_pkg::ST_EVAL)
    else $error("accepted item not evaluated");

  a_halt_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == srdg_pkg::ST_OUT && halt_q |-> ramp_index_q == '0)
    else $error("halt left a nonzero ramp index");
`endif

endmodule

FILE: rtl/srdg_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module srdg_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [srdg_pkg::DivBits-1:0]   num_i,
  input  logic [srdg_pkg::DivBits-1:0]   den_i,
  output logic                           done_o,
  output logic [srdg_pkg::DivBits-1:0]   quo_o
);

  logic [srdg_pkg::DivBits-1:0] num_q, num_d;
  logic [srdg_pkg::DivBits-1:0] rem_q, rem_d;
  logic [srdg_pkg::DivBits-1:0] den_q, den_d;
  logic [srdg_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [srdg_pkg::DivBits:0]   trial;
  logic [srdg_pkg::DivBits+1:0] diff;
  logic                         ge;

  assign trial = {rem_q, num_q[srdg_pkg::DivBits-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};
  assign ge    = ~diff[srdg_pkg::DivBits+1];

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[srdg_pkg::DivBits-1:0] : trial[srdg_pkg::DivBits-1:0];
      num_d = {num_q[srdg_pkg::DivBits-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == srdg_pkg::DivCntW'(srdg_pkg::DivBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule
